[hw/rtl/mlht_pkg.sv]
package mlht_pkg;

	// Table geometry
	localparam int SLOTS   = 64;
	localparam int WAYS    = 4;
	localparam int ENTRIES = WAYS * SLOTS;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int LVL_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

	// Field widths
	localparam int ACT_W   = 2;
	localparam int STAT_W  = 2;
	localparam int KEY_W   = 64;
	localparam int HASH_W  = 32;
	localparam int VAL_W   = 64;
	localparam int COUNT_W = 9;

	// Request actions
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_PRESENT   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

	// One stored entry and one memory row (all levels of one slot)
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	// Request sequencer
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

endpackage

[hw/rtl/multi_level_hash_table_unit.sv]
// Hash table of WAYS levels by SLOTS slots held in one row-wide memory: every
// slot is one row with all its levels, so one read fetches the whole chain.
// A request word goes from acceptance to its result by addressing the row,
// capturing the row, then comparing all levels at once and writing the row back;
// a new word is taken only once the previous one has executed. The result sits
// in an output register, so the next word is accepted while it waits; execution
// holds only if the previous result is still not taken.
// Key zero answers not found. Valid bits are flip-flops cleared at reset, so the
// table is usable right after reset with no clearing pass.
module multi_level_hash_table_unit
	import mlht_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic [KEY_W-1:0]   key_ident,
	input  logic [HASH_W-1:0]  key_hash,
	input  logic [VAL_W-1:0]   new_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [VAL_W-1:0]   read_value,
	output logic [COUNT_W-1:0] entry_count
);

	state_t               state_q;
	logic [ACT_W-1:0]     action_q;
	logic [KEY_W-1:0]     key_q;
	logic [VAL_W-1:0]     value_q;
	logic [SLOT_W-1:0]    slot_q;
	row_t                 row_q;
	logic [WAYS-1:0]      vrow_q;
	logic [WAYS-1:0]      valid_q [SLOTS];
	logic [COUNT_W-1:0]   count_q;

	logic                 out_valid_q;
	logic [STAT_W-1:0]    status_q;
	logic [VAL_W-1:0]     read_value_q;

	logic                 in_acc;
	logic                 exec_go;
	logic [SLOT_W-1:0]    in_slot;
	logic [ROW_W-1:0]     ram_rdata;

	logic [WAYS-1:0]      hit_vec;
	logic                 hit_any;
	logic                 full;
	logic [LVL_W-1:0]     hit_lvl;
	logic [LVL_W-1:0]     free_lvl;
	logic [LVL_W-1:0]     last_lvl;

	row_t                 new_row;
	logic [WAYS-1:0]      new_vrow;
	logic                 write_d;
	logic [STAT_W-1:0]    status_d;
	logic [VAL_W-1:0]     read_value_d;
	logic [COUNT_W-1:0]   count_d;

	// Handshake
	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign exec_go     = (state_q == ST_EXEC) && !(out_valid_q && out_stall);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = count_q;

	// Slot select: SLOTS is a power of two, so this is a bit slice
	assign in_slot = SLOT_W'(key_hash % HASH_W'(SLOTS));

	// Row memory, addressed by the incoming slot at acceptance
	mlht_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SLOTS)
	) u_row_ram (
		.clk   (clk),
		.we    (exec_go && write_d),
		.waddr (slot_q),
		.wdata (new_row),
		.raddr (in_slot),
		.rdata (ram_rdata)
	);

	// Probe all levels of the captured row
	always_comb begin
		hit_vec  = '0;
		hit_lvl  = '0;
		free_lvl = '0;
		last_lvl = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = vrow_q[w] && (row_q[w].key == key_q);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_lvl = LVL_W'(w);
			end
			if (!vrow_q[w]) begin
				free_lvl = LVL_W'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (vrow_q[w]) begin
				last_lvl = LVL_W'(w);
			end
		end
		hit_any = |hit_vec;
		full    = &vrow_q;
	end

	// Execute the action and build the row to write back
	always_comb begin
		new_row      = row_q;
		new_vrow     = vrow_q;
		write_d      = 1'b0;
		status_d     = STAT_NOT_FOUND;
		read_value_d = '0;
		count_d      = count_q;
		if (key_q != '0) begin
			case (action_q)
				ACT_INSERT: begin
					if (hit_any) begin
						status_d = STAT_PRESENT;
					end else if (!full) begin
						new_row[free_lvl].key   = key_q;
						new_row[free_lvl].value = value_q;
						new_vrow[free_lvl]      = 1'b1;
						write_d                 = 1'b1;
						count_d                 = count_q + 1'b1;
						status_d                = STAT_OK;
					end else begin
						status_d = STAT_FULL;
					end
				end
				ACT_UPDATE: begin
					if (hit_any) begin
						new_row[hit_lvl].value = value_q;
						write_d                = 1'b1;
						status_d               = STAT_OK;
					end
				end
				ACT_LOOKUP: begin
					if (hit_any) begin
						read_value_d = row_q[hit_lvl].value;
						status_d     = STAT_OK;
					end
				end
				ACT_REMOVE: begin
					if (hit_any) begin
						// Move the last entry of the chain into the hole
						new_row[hit_lvl]   = row_q[last_lvl];
						new_vrow[last_lvl] = 1'b0;
						write_d            = 1'b1;
						count_d            = count_q - 1'b1;
						status_d           = STAT_OK;
					end
				end
				default: begin
					status_d = STAT_NOT_FOUND;
				end
			endcase
		end
	end

	// Sequence the request and hold the valid map and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				valid_q[s] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_go) begin
				valid_q[slot_q] <= new_vrow;
				count_q         <= count_d;
				out_valid_q     <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the request word, the fetched row and the result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q <= action;
			key_q    <= key_ident;
			value_q  <= new_value;
			slot_q   <= in_slot;
		end
		if (state_q == ST_READ) begin
			row_q  <= ram_rdata;
			vrow_q <= valid_q[slot_q];
		end
		if (exec_go) begin
			status_q     <= status_d;
			read_value_q <= read_value_d;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(ENTRIES))
		else $error("entry count above table size");

	a_chain_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> (((vrow_q + 1'b1) & vrow_q) == '0))
		else $error("occupied levels of a slot are not a run from level zero");

	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result word raised outside execution");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && (action_q == ACT_INSERT) && (status_d == STAT_OK))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("successful insert did not raise the count");
`endif

endmodule

[hw/rtl/mlht_ram.sv]
module mlht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[bench/mlht_result_checker.sv]
`timescale 1ns / 100ps

module mlht_result_checker
	import mlht_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic [KEY_W-1:0]   key_ident,
	input  logic [HASH_W-1:0]  key_hash,
	input  logic [VAL_W-1:0]   new_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [STAT_W-1:0]  status,
	input  logic [VAL_W-1:0]   read_value,
	input  logic [COUNT_W-1:0] entry_count,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [VAL_W-1:0]   read_value;
		logic [COUNT_W-1:0] entry_count;
	} table_answer_t;

	// Shadow copy of the table
	logic               tbl_valid [ENTRIES];
	logic [KEY_W-1:0]   tbl_key   [ENTRIES];
	logic [HASH_W-1:0]  tbl_hash  [ENTRIES];
	logic [VAL_W-1:0]   tbl_value [ENTRIES];
	logic [COUNT_W-1:0] tbl_count;

	table_answer_t answer_queue [$];

	// Apply one request word to the shadow table and return its answer
	function automatic table_answer_t apply_request(
		input logic [ACT_W-1:0]  act,
		input logic [KEY_W-1:0]  key,
		input logic [HASH_W-1:0] hash,
		input logic [VAL_W-1:0]  val
	);
		int unsigned   slot;
		int unsigned   hit;
		int unsigned   free_lvl;
		int unsigned   last;
		int unsigned   e;
		int unsigned   s;
		int unsigned   w;
		table_answer_t ans;

		slot = hash % SLOTS;
		ans.status = STAT_NOT_FOUND;
		ans.read_value = '0;
		if (key != '0) begin
			// Walk the chain until the key or the first hole
			hit = WAYS;
			free_lvl = WAYS;
			for (w = 0; w < WAYS; w++) begin
				e = w * SLOTS + slot;
				if (!tbl_valid[e]) begin
					free_lvl = w;
					break;
				end
				if (tbl_key[e] == key) begin
					hit = w;
					break;
				end
			end

			if (act == ACT_INSERT) begin
				if (hit < WAYS) begin
					ans.status = STAT_PRESENT;
				end else if (free_lvl < WAYS) begin
					e = free_lvl * SLOTS + slot;
					tbl_valid[e] = 1'b1;
					tbl_key[e] = key;
					tbl_hash[e] = hash;
					tbl_value[e] = val;
					tbl_count = tbl_count + 1'b1;
					ans.status = STAT_OK;
				end else begin
					ans.status = STAT_FULL;
				end
			end else if (hit < WAYS) begin
				e = hit * SLOTS + slot;
				ans.status = STAT_OK;
				if (act == ACT_UPDATE) begin
					tbl_hash[e] = hash;
					tbl_value[e] = val;
				end else if (act == ACT_LOOKUP) begin
					ans.read_value = tbl_value[e];
				end else begin
					// Fill the hole with the last occupied later level
					last = hit;
					for (w = hit + 1; w < WAYS; w++) begin
						if (!tbl_valid[w * SLOTS + slot])
							break;
						last = w;
					end
					if (last != hit) begin
						s = last * SLOTS + slot;
						tbl_key[e] = tbl_key[s];
						tbl_hash[e] = tbl_hash[s];
						tbl_value[e] = tbl_value[s];
						e = s;
					end
					tbl_valid[e] = 1'b0;
					tbl_key[e] = '0;
					tbl_hash[e] = '0;
					tbl_value[e] = '0;
					if (tbl_count != '0)
						tbl_count = tbl_count - 1'b1;
				end
			end
		end
		ans.entry_count = tbl_count;
		return ans;
	endfunction

	// Compare result words first, then record the request word of the same edge
	always @(posedge clk) begin
		table_answer_t want;
		int            i;

		if (!arst_n) begin
			for (i = 0; i < ENTRIES; i++)
				tbl_valid[i] = 1'b0;
			tbl_count = '0;
			answer_queue.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (answer_queue.size() == 0) begin
					$error("result word with no request outstanding");
					errors++;
				end else begin
					want = answer_queue.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, status);
						errors++;
					end
					if (read_value !== want.read_value) begin
						$error("read_value mismatch: expected %h, actual %h",
							want.read_value, read_value);
						errors++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count mismatch: expected %0d, actual %0d",
							want.entry_count, entry_count);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				answer_queue.push_back(apply_request(action, key_ident, key_hash, new_value));
		end
		pending = answer_queue.size();
	end

endmodule

[bench/multi_level_hash_table_unit_tb.sv]
`timescale 1ns / 100ps

module multi_level_hash_table_unit_tb;
	import mlht_pkg::*;

	localparam int ITEMS          = 1200;
	localparam int PHASES         = 6;
	localparam int POOL           = 24;
	localparam int HOT_SLOTS      = 4;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 20;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [ACT_W-1:0]   action;
	logic [KEY_W-1:0]   key_ident;
	logic [HASH_W-1:0]  key_hash;
	logic [VAL_W-1:0]   new_value;
	logic               out_valid;
	logic               out_stall;
	logic [STAT_W-1:0]  status;
	logic [VAL_W-1:0]   read_value;
	logic [COUNT_W-1:0] entry_count;

	int errors;
	int pending;
	int idle_cycles;
	bit calm_phase;
	bit long_hold_req;

	// Key pool of the current phase, crowded into a few slots
	logic [KEY_W-1:0] pool_key  [POOL];
	int unsigned      pool_slot [POOL];

	multi_level_hash_table_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key_ident   (key_ident),
		.key_hash    (key_hash),
		.new_value   (new_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

	mlht_result_checker u_result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key_ident   (key_ident),
		.key_hash    (key_hash),
		.new_value   (new_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count),
		.errors      (errors),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort when no word moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("multi_level_hash_table_unit_tb: done, errors");
			$finish;
		end
	end

	// Pick a gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;

		r = $urandom_range(0, 99);
		if (calm_phase || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Hash with random upper bits that lands on a chosen slot
	function automatic logic [HASH_W-1:0] slotted_hash(input int unsigned slot);
		logic [HASH_W-1:0] h;

		h = $urandom;
		return h - (h % SLOTS) + slot;
	endfunction

	// Receiver: stall in runs of random length, or hold off long on request
	initial begin
		int hold_left;
		bit stall_now;
		int r;

		hold_left = 0;
		stall_now = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_now = 1'b1;
				hold_left = LONG_HOLD;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (calm_phase) begin
				stall_now = 1'b0;
			end else begin
				stall_now = ($urandom_range(0, 99) < 40);
				r = $urandom_range(0, 99);
				if (r < 70)
					hold_left = $urandom_range(0, 2);
				else if (r < 95)
					hold_left = $urandom_range(3, 9);
				else
					hold_left = $urandom_range(15, 40);
			end
			out_stall <= stall_now;
		end
	end

	// Offer one request word, hold it until taken, then idle for a random gap, possibly none
	task automatic send_word(
		input logic [ACT_W-1:0]  act,
		input logic [KEY_W-1:0]  key,
		input logic [HASH_W-1:0] hash,
		input logic [VAL_W-1:0]  val
	);
		int gap;

		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		key_ident <= key;
		key_hash <= hash;
		new_value <= val;
		do
			@(posedge clk);
		while (in_stall);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every answer is back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
	endtask

	// Fill the key pool with fresh keys over a few fresh slots
	task automatic refresh_pool();
		int unsigned hot [HOT_SLOTS];
		int          i;

		for (i = 0; i < HOT_SLOTS; i++)
			hot[i] = $urandom_range(0, SLOTS - 1);
		for (i = 0; i < POOL; i++) begin
			pool_key[i] = {$urandom, $urandom};
			pool_slot[i] = hot[i % HOT_SLOTS];
		end
	endtask

	// One random word: mostly pool keys on crowded slots, some noise and key zero
	task automatic send_random_word();
		int                r;
		int                idx;
		logic [ACT_W-1:0]  act;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;

		idx = $urandom_range(0, POOL - 1);
		key = pool_key[idx];
		hash = slotted_hash(pool_slot[idx]);
		r = $urandom_range(0, 99);
		if (r < 3) begin
			key = '0;
		end else if (r < 12) begin
			key = {$urandom, $urandom};
			hash = $urandom;
		end
		r = $urandom_range(0, 99);
		if (r < 35)
			act = ACT_INSERT;
		else if (r < 50)
			act = ACT_UPDATE;
		else if (r < 75)
			act = ACT_LOOKUP;
		else
			act = ACT_REMOVE;
		send_word(act, key, hash, {$urandom, $urandom});
	endtask

	initial begin
		logic [HASH_W-1:0] hash_a;
		logic [KEY_W-1:0]  k1;
		logic [KEY_W-1:0]  k2;
		logic [KEY_W-1:0]  k3;
		logic [KEY_W-1:0]  k4;
		logic [KEY_W-1:0]  k5;
		logic [KEY_W-1:0]  k6;
		int                p;
		int                n;

		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_INSERT;
		key_ident = '0;
		key_hash = '0;
		new_value = '0;
		idle_cycles = 0;
		calm_phase = 1'b0;
		long_hold_req = 1'b0;
		hash_a = '1;
		k1 = 64'h0000_0000_0000_0001;
		k2 = '1;
		k3 = 64'h8000_0000_0000_0000;
		k4 = 64'h5555_5555_5555_5555;
		k5 = 64'hAAAA_AAAA_AAAA_AAAA;
		k6 = 64'h0123_4567_89AB_CDEF;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, duplicates, full chain, remove with and without fill
		send_word(ACT_INSERT, '0, hash_a, '1);
		send_word(ACT_LOOKUP, k1, hash_a, '0);
		send_word(ACT_REMOVE, k1, hash_a, '0);
		send_word(ACT_UPDATE, k1, hash_a, '1);
		send_word(ACT_INSERT, k1, hash_a, '1);
		send_word(ACT_INSERT, k1, hash_a, 64'h1234);
		send_word(ACT_UPDATE, k1, hash_a, '0);
		send_word(ACT_LOOKUP, k1, hash_a, '1);
		send_word(ACT_INSERT, k2, hash_a, 64'hDEAD_BEEF_0000_0002);
		send_word(ACT_INSERT, k3, hash_a, 64'hDEAD_BEEF_0000_0003);
		send_word(ACT_INSERT, k4, hash_a, 64'hDEAD_BEEF_0000_0004);
		send_word(ACT_INSERT, k5, hash_a, 64'hDEAD_BEEF_0000_0005);
		send_word(ACT_REMOVE, k2, hash_a, '0);
		send_word(ACT_LOOKUP, k4, hash_a, '0);
		send_word(ACT_REMOVE, k4, hash_a, '0);
		send_word(ACT_LOOKUP, k3, hash_a, '0);
		send_word(ACT_REMOVE, k3, hash_a, '0);
		send_word(ACT_REMOVE, k1, hash_a, '0);
		send_word(ACT_LOOKUP, k1, hash_a, '0);
		send_word(ACT_UPDATE, '0, '0, '1);
		send_word(ACT_LOOKUP, '0, '0, '0);
		send_word(ACT_REMOVE, '0, '0, '0);
		send_word(ACT_INSERT, k6, '0, '1);
		send_word(ACT_UPDATE, k6, 32'h8000_0000, 64'h0F0F_0F0F_0F0F_0F0F);
		send_word(ACT_LOOKUP, k6, '0, '0);
		drain_results();

		// Random phases, each on a fresh pool; one calm, one with a long hold-off
		for (p = 0; p < PHASES; p++) begin
			refresh_pool();
			calm_phase = (p == 2);
			for (n = 0; n < ITEMS / PHASES; n++) begin
				if (p == 3 && n == 20)
					long_hold_req = 1'b1;
				send_random_word();
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("multi_level_hash_table_unit_tb: done, clean");
		else
			$display("multi_level_hash_table_unit_tb: done, errors");
		$finish;
	end

endmodule
